>>> rtl/flash_journal_record_scanner_core_macros.svh
// ----------------------------------------------------------------------------
// flash journal record scanner assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef FLASH_JOURNAL_RECORD_SCANNER_CORE_MACROS_SVH
`define FLASH_JOURNAL_RECORD_SCANNER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define FJRS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FJRS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define FJRS_ASSERT(label, clk, rstn, prop, msg)
`define FJRS_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`endif

`endif

>>> rtl/fjrs_pkg.sv
// ----------------------------------------------------------------------------
// fjrs_pkg
// shared constants, item and result types and the word-wide crc-32 update
// ----------------------------------------------------------------------------
`default_nettype none

package fjrs_pkg;

    localparam int LOG_BLOCKS     = 128;
    localparam int ERASED_ONES    = 1;
    localparam int MAX_FILE_BYTES = 504;

    localparam int BIDX_W   = $clog2(LOG_BLOCKS + 1);
    localparam int WORDS    = 8;
    localparam int WORD_W   = 32;
    localparam int WCNT_W   = $clog2(WORDS);
    localparam int ID_W     = 6;
    localparam int NUM_IDS  = 64;
    localparam int SIZE_W   = 9;
    localparam int START_W  = 7;
    localparam int REM_W    = 10;
    localparam int DATA_W   = WORDS * WORD_W;
    localparam int OUT_W    = 32;

    // power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] CRC_POLY = 32'hedb88320;

    localparam logic [1:0] KIND_ENTRY = (ERASED_ONES != 0) ? 2'd3 : 2'd0;
    localparam logic [1:0] KIND_START = (ERASED_ONES != 0) ? 2'd1 : 2'd2;
    localparam logic       KIND_CONT  = (ERASED_ONES != 0) ? 1'b0 : 1'b1;

    localparam int FIRST_LAST_BYTES = 28 - 4;
    localparam int CONT_LAST_BYTES  = 32 - 4;
    localparam int FIRST_PAYLOAD    = 28;
    localparam int CONT_PAYLOAD     = 32;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT_C = 2'd2;

    typedef struct packed {
        logic [WORDS-1:0][WORD_W-1:0] words;
        logic                         present;
        logic                         eol;
        logic                         entry_kind;
        logic                         is_start;
        logic                         is_cont;
        logic                         ident_match;
        logic                         size_ok;
        logic [ID_W-1:0]              id;
        logic [SIZE_W-1:0]            size;
    } item_t;

    typedef struct packed {
        logic               entry_found;
        logic [ID_W-1:0]    file_id;
        logic               ids_exhausted;
        logic               data_found;
        logic [START_W-1:0] data_start_index;
        logic [SIZE_W-1:0]  file_size;
    } result_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    // raw (non-inverted) crc register advanced by one word, low byte first;
    // linear in the input, so it flattens to an xor network
    function automatic logic [31:0] crc32_word(input logic [31:0] crc_in,
                                               input logic [31:0] data);
        logic [31:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 32; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fjrs_front.sv
// ----------------------------------------------------------------------------
// fjrs_front
// identifier registers, block classification and the short item queue
// ----------------------------------------------------------------------------
`default_nettype none

module fjrs_front
    import fjrs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DATA_W-1:0]    s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 s_tuser,
    output item_t                     head_item,
    output logic                      head_valid,
    input  wire logic                 head_pop,
    output queue_status_t             q_status
);

    logic [WORD_W-1:0] ident_a_reg, ident_b_reg, ident_c_reg;

    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;
    item_t             in_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ident_a_reg <= '0;
            ident_b_reg <= '0;
            ident_c_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IDENT_A: ident_a_reg <= cfg_data;
                CFG_IDENT_B: ident_b_reg <= cfg_data;
                CFG_IDENT_C: ident_c_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item             = '0;
        in_item.words       = s_tdata;
        in_item.present     = s_tuser;
        in_item.eol         = s_tlast;
        in_item.entry_kind  = (s_tdata[1:0] == KIND_ENTRY);
        in_item.is_start    = (s_tdata[1:0] == KIND_START);
        in_item.is_cont     = (s_tdata[0] == KIND_CONT);
        in_item.ident_match = (s_tdata[63:32] == ident_a_reg) &&
                              (s_tdata[95:64] == ident_b_reg) &&
                              (s_tdata[127:96] == ident_c_reg);
        in_item.id          = s_tdata[7:2];
        in_item.size        = s_tdata[16:8];
        in_item.size_ok     = (s_tdata[16:8] <= SIZE_W'(MAX_FILE_BYTES));
    end

    assign s_tready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign pop        = head_pop && head_valid;
    assign head_item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q_status.count = count_reg;

endmodule

`default_nettype wire

>>> rtl/fjrs_back.sv
// ----------------------------------------------------------------------------
// fjrs_back
// scan state, word-serial crc-32 engine and end-of-log result
// ----------------------------------------------------------------------------
`default_nettype none

module fjrs_back
    import fjrs_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire item_t head_item,
    input  wire logic  head_valid,
    output logic       head_pop,
    input  wire logic  out_free,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_CRC  = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    localparam logic [1:0] PH_ENTRY = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_CONT  = 2'd2;

    logic [1:0]               bstate_reg, bstate_next;
    logic [1:0]               phase_reg, phase_next;
    logic [BIDX_W-1:0]        bidx_reg, bidx_next;
    logic [NUM_IDS-1:0]       used_map_reg, used_map_next;
    logic [ID_W-1:0]          matched_reg, matched_next;
    logic signed [REM_W-1:0]  rem_reg, rem_next;
    logic [31:0]              chain_reg, chain_next;
    logic [START_W-1:0]       cand_start_reg, cand_start_next;
    logic [SIZE_W-1:0]        cand_size_reg, cand_size_next;
    logic [START_W-1:0]       best_start_reg, best_start_next;
    logic [SIZE_W-1:0]        best_size_reg, best_size_next;
    logic                     best_valid_reg, best_valid_next;
    logic [31:0]              crc_reg, crc_next;
    logic [WCNT_W-1:0]        wcnt_reg, wcnt_next;

    logic              in_log, take, need_crc, crc_ok, found, exhausted;
    logic [31:0]       seed, crc_step;
    logic [ID_W-1:0]   free_id;

    assign in_log = (bidx_reg < BIDX_W'(LOG_BLOCKS));
    assign take   = head_item.present && in_log;

    always_comb begin
        unique case (phase_reg)
            PH_ENTRY: need_crc = take && head_item.entry_kind;
            PH_START: need_crc = take && head_item.is_start && head_item.size_ok &&
                                 (head_item.id == matched_reg);
            PH_CONT:  need_crc = take && head_item.is_cont;
            default:  need_crc = 1'b0;
        endcase
    end

    // a continuation block picks up the chained value, everything else starts fresh
    assign seed     = (bstate_reg == B_IDLE) ?
                      ((phase_reg == PH_CONT) ? chain_reg : '1) : crc_reg;
    assign crc_step = crc32_word(seed, (bstate_reg == B_IDLE) ? head_item.words[0]
                                                               : head_item.words[wcnt_reg]);
    // after seven words the register holds the crc of words zero to six
    assign crc_ok   = (~crc_reg == head_item.words[WORDS-1]);

    assign found     = (phase_reg != PH_ENTRY);
    assign exhausted = &used_map_reg;

    always_comb begin
        free_id = '0;
        for (int i = NUM_IDS - 1; i >= 0; i--) begin
            if (!used_map_reg[i]) begin
                free_id = ID_W'(i);
            end
        end
    end

    always_comb begin
        res                  = '0;
        res.entry_found      = found;
        res.file_id          = found ? matched_reg : (exhausted ? '0 : free_id);
        res.ids_exhausted    = !found && exhausted;
        res.data_found       = found && best_valid_reg;
        res.data_start_index = (found && best_valid_reg) ? best_start_reg : '0;
        res.file_size        = (found && best_valid_reg) ? best_size_reg : '0;
    end

    always_comb begin
        bstate_next     = bstate_reg;
        phase_next      = phase_reg;
        bidx_next       = bidx_reg;
        used_map_next   = used_map_reg;
        matched_next    = matched_reg;
        rem_next        = rem_reg;
        chain_next      = chain_reg;
        cand_start_next = cand_start_reg;
        cand_size_next  = cand_size_reg;
        best_start_next = best_start_reg;
        best_size_next  = best_size_reg;
        best_valid_next = best_valid_reg;
        crc_next        = crc_reg;
        wcnt_next       = wcnt_reg;
        head_pop        = 1'b0;
        res_valid       = 1'b0;

        unique case (bstate_reg)
            B_IDLE: begin
                if (head_valid) begin
                    if (need_crc) begin
                        crc_next    = crc_step;
                        wcnt_next   = WCNT_W'(1);
                        bstate_next = B_CRC;
                    end else begin
                        if (take) begin
                            bidx_next = bidx_reg + 1'b1;
                            // chain broken by a block of another kind
                            if (phase_reg == PH_CONT) begin
                                phase_next = PH_START;
                            end
                        end
                        if (head_item.eol) begin
                            bstate_next = B_EMIT;
                        end else begin
                            head_pop = 1'b1;
                        end
                    end
                end
            end
            B_CRC: begin
                if (wcnt_reg != WCNT_W'(WORDS - 1)) begin
                    crc_next  = crc_step;
                    wcnt_next = wcnt_reg + 1'b1;
                end else begin
                    bidx_next = bidx_reg + 1'b1;
                    unique case (phase_reg)
                        PH_ENTRY: begin
                            if (crc_ok) begin
                                if (head_item.ident_match) begin
                                    matched_next = head_item.id;
                                    phase_next   = PH_START;
                                end else begin
                                    used_map_next[head_item.id] = 1'b1;
                                end
                            end
                        end
                        PH_START: begin
                            cand_start_next = bidx_reg[START_W-1:0];
                            cand_size_next  = head_item.size;
                            if (head_item.size <= SIZE_W'(FIRST_LAST_BYTES)) begin
                                // whole file fits in the start block
                                if (crc_ok) begin
                                    best_start_next = bidx_reg[START_W-1:0];
                                    best_size_next  = head_item.size;
                                    best_valid_next = 1'b1;
                                end
                            end else begin
                                rem_next   = $signed(REM_W'(head_item.size)) -
                                             $signed(REM_W'(FIRST_PAYLOAD));
                                chain_next = crc_step;
                                phase_next = PH_CONT;
                            end
                        end
                        PH_CONT: begin
                            if (rem_reg <= $signed(REM_W'(CONT_LAST_BYTES))) begin
                                if (crc_ok) begin
                                    best_start_next = cand_start_reg;
                                    best_size_next  = cand_size_reg;
                                    best_valid_next = 1'b1;
                                end
                                phase_next = PH_START;
                            end else begin
                                rem_next   = rem_reg - $signed(REM_W'(CONT_PAYLOAD));
                                chain_next = crc_step;
                            end
                        end
                        default: ;
                    endcase
                    if (head_item.eol) begin
                        bstate_next = B_EMIT;
                    end else begin
                        head_pop    = 1'b1;
                        bstate_next = B_IDLE;
                    end
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    res_valid       = 1'b1;
                    head_pop        = 1'b1;
                    bstate_next     = B_IDLE;
                    phase_next      = PH_ENTRY;
                    bidx_next       = BIDX_W'(1);
                    used_map_next   = '0;
                    matched_next    = '0;
                    rem_next        = '0;
                    chain_next      = '0;
                    cand_start_next = '0;
                    cand_size_next  = '0;
                    best_start_next = '0;
                    best_size_next  = '0;
                    best_valid_next = 1'b0;
                end
            end
            default: begin
                bstate_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bstate_reg     <= B_IDLE;
            phase_reg      <= PH_ENTRY;
            bidx_reg       <= BIDX_W'(1);
            used_map_reg   <= '0;
            matched_reg    <= '0;
            rem_reg        <= '0;
            chain_reg      <= '0;
            cand_start_reg <= '0;
            cand_size_reg  <= '0;
            best_start_reg <= '0;
            best_size_reg  <= '0;
            best_valid_reg <= 1'b0;
            wcnt_reg       <= '0;
        end else begin
            bstate_reg     <= bstate_next;
            phase_reg      <= phase_next;
            bidx_reg       <= bidx_next;
            used_map_reg   <= used_map_next;
            matched_reg    <= matched_next;
            rem_reg        <= rem_next;
            chain_reg      <= chain_next;
            cand_start_reg <= cand_start_next;
            cand_size_reg  <= cand_size_next;
            best_start_reg <= best_start_next;
            best_size_reg  <= best_size_next;
            best_valid_reg <= best_valid_next;
            wcnt_reg       <= wcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg <= crc_next;
    end

endmodule

`default_nettype wire

>>> rtl/flash_journal_record_scanner_core.sv
// ----------------------------------------------------------------------------
// flash_journal_record_scanner_core
// a block that needs a crc check runs through the crc engine one word per cycle,
// word zero in the idle state and words one to six in the crc state, before it
// is popped; other blocks are popped from the idle state, and the end of log
// passes through the emit state into the output word register
// reset: synchronous on aresetn low, scan restarts at block 1, identifier zero
// ----------------------------------------------------------------------------
`default_nettype none
`include "flash_journal_record_scanner_core_macros.svh"

module flash_journal_record_scanner_core
    import fjrs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // word0, word1, word2, word3, word4, word5, word6, word7
    input  wire logic [DATA_W-1:0]    s_tdata,
    input  wire logic                 s_tlast,
    // block_present
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // entry_found, file_id, ids_exhausted, data_found, data_start_index,
    // file_size, zero fill
    output logic [OUT_W-1:0]          m_tdata
);

    item_t         head_item;
    logic          head_valid, head_pop;
    queue_status_t q_status;
    logic          out_free, res_valid;
    result_t       res;
    result_t       out_reg;
    logic          m_valid_reg;

    fjrs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .head_item  (head_item),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .q_status   (q_status)
    );

    fjrs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_item  (head_item),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res)
    );

    // output word register, the back end keeps working while it waits
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0,
                       out_reg.file_size,
                       out_reg.data_start_index,
                       out_reg.data_found,
                       out_reg.ids_exhausted,
                       out_reg.file_id,
                       out_reg.entry_found};

    `FJRS_ASSERT_IMP(a_res_into_free_slot, aclk, aresetn, res_valid, out_free, "result produced while output word still held")
    `FJRS_ASSERT(a_queue_bound, aclk, aresetn, (q_status.count <= QCNT_W'(QUEUE_DEPTH)), "item queue overfilled")
    `FJRS_ASSERT_IMP(a_exhausted_no_match, aclk, aresetn, (m_tvalid && m_tdata[7]), (!m_tdata[0] && (m_tdata[6:1] == '0)), "ids exhausted with a match or nonzero id")
    `FJRS_ASSERT_IMP(a_data_needs_entry, aclk, aresetn, (m_tvalid && m_tdata[8]), m_tdata[0], "data found without a matched entry")

endmodule

`default_nettype wire

>>> tb/sv/flash_journal_record_scanner_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_journal_record_scanner_core_tb
// feeds directed and random journals (entries, data chains, noise, end
// markers) under varied identifier settings and random stalls on both sides;
// every end-of-log result word is checked field by field against a scan model
// ----------------------------------------------------------------------------

module flash_journal_record_scanner_core_tb;
    import fjrs_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int ITEM_TARGET   = 650;
    localparam int RESULT_TARGET = 40;
    localparam int SETTLE_CYCLES = 30;
    localparam int SIZE_FIELD_MAX = (1 << SIZE_W) - 1;

    typedef logic [WORDS-1:0][WORD_W-1:0] block_t;

    typedef struct packed {
        logic   present;
        logic   eol;
        block_t words;
    } journal_item_t;

    typedef enum logic [1:0] {SEEK_ENTRY, SEEK_START, IN_CHAIN} scan_phase_e;
    typedef enum int {CHAIN_GOOD, CHAIN_BAD_CRC, CHAIN_BROKEN} chain_fault_e;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    flash_journal_record_scanner_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // scan model state
    logic [WORD_W-1:0]  ident_regs [3];
    scan_phase_e        scan_phase;
    int                 blk_idx;
    logic [NUM_IDS-1:0] used_ids;
    logic [ID_W-1:0]    matched_id;
    int                 bytes_left;
    logic [31:0]        chain_crc;
    logic [START_W-1:0] cand_start;
    logic [START_W-1:0] best_start;
    logic [SIZE_W-1:0]  cand_size;
    logic [SIZE_W-1:0]  best_size;
    logic               best_valid;
    result_t            expected_results [$];

    // stimulus side
    logic [WORD_W-1:0]  ident_target [3];
    journal_item_t      pending_items [$];
    journal_item_t      on_bus;
    int                 send_gap = 0;
    int                 ready_hold = 0;
    bit                 steady = 1'b0;

    int items_queued = 0;
    int items_sent = 0;
    int predicted_results = 0;
    int results_checked = 0;
    int matches_predicted = 0;
    int chains_predicted = 0;
    int exhausted_predicted = 0;
    int regs_written = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int phase_no = 0;
    int journals = 0;

    // crc-32 over the first n words, low byte first, seed and result finalized
    function automatic logic [31:0] journal_crc(input logic [31:0] seed, input block_t w,
                                                input int n_words);
        logic [31:0] c;
        c = ~seed;
        for (int i = 0; i < n_words; i++) begin
            for (int b = 0; b < 4; b++) begin
                c = c ^ {24'd0, w[i][8*b +: 8]};
                for (int k = 0; k < 8; k++) begin
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
                end
            end
        end
        return ~c;
    endfunction

    function automatic void restart_scan();
        scan_phase = SEEK_ENTRY;
        blk_idx    = 1;
        used_ids   = '0;
        matched_id = '0;
        bytes_left = 0;
        chain_crc  = '0;
        cand_start = '0;
        cand_size  = '0;
        best_start = '0;
        best_size  = '0;
        best_valid = 1'b0;
    endfunction

    function automatic void close_chain(input block_t w, input logic [31:0] seed);
        if (journal_crc(seed, w, WORDS - 1) == w[WORDS-1]) begin
            best_start = cand_start;
            best_size  = cand_size;
            best_valid = 1'b1;
        end
        scan_phase = SEEK_START;
    endfunction

    task automatic scan_item(input journal_item_t it);
        block_t            w;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        result_t           r;
        w    = it.words;
        id   = w[0][ID_W+1:2];
        size = w[0][SIZE_W+7:8];
        if (it.present && blk_idx < LOG_BLOCKS) begin
            case (scan_phase)
                SEEK_ENTRY: begin
                    if (w[0][1:0] == KIND_ENTRY && journal_crc('0, w, WORDS - 1) == w[WORDS-1]) begin
                        if (w[1] == ident_regs[CFG_IDENT_A] && w[2] == ident_regs[CFG_IDENT_B]
                                && w[3] == ident_regs[CFG_IDENT_C]) begin
                            matched_id = id;
                            scan_phase = SEEK_START;
                        end else begin
                            used_ids[id] = 1'b1;
                        end
                    end
                end
                SEEK_START: begin
                    if (w[0][1:0] == KIND_START && id == matched_id && size <= MAX_FILE_BYTES) begin
                        cand_start = START_W'(blk_idx);
                        cand_size  = size;
                        if (size <= FIRST_LAST_BYTES) begin
                            close_chain(w, '0);
                        end else begin
                            bytes_left = int'(size) - FIRST_PAYLOAD;
                            chain_crc  = journal_crc('0, w, WORDS);
                            scan_phase = IN_CHAIN;
                        end
                    end
                end
                default: begin
                    // any non-continuation block kills the chain and is dropped
                    if (w[0][0] != KIND_CONT) begin
                        scan_phase = SEEK_START;
                    end else if (bytes_left <= CONT_LAST_BYTES) begin
                        close_chain(w, chain_crc);
                    end else begin
                        bytes_left -= CONT_PAYLOAD;
                        chain_crc = journal_crc(chain_crc, w, WORDS);
                    end
                end
            endcase
            blk_idx++;
        end
        if (!it.eol) return;
        r = '0;
        if (scan_phase == SEEK_ENTRY) begin
            if (&used_ids) begin
                r.ids_exhausted = 1'b1;
                exhausted_predicted++;
            end else begin
                for (int i = NUM_IDS - 1; i >= 0; i--) begin
                    if (!used_ids[i]) r.file_id = ID_W'(i);
                end
            end
        end else begin
            r.entry_found = 1'b1;
            r.file_id     = matched_id;
            matches_predicted++;
            if (best_valid) begin
                r.data_found       = 1'b1;
                r.data_start_index = best_start;
                r.file_size        = best_size;
                chains_predicted++;
            end
        end
        expected_results.push_back(r);
        predicted_results++;
        restart_scan();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result %0d: %s got 0x%0h want 0x%0h", $realtime, results_checked, what,
                 got, want);
        mismatches++;
    endtask

    task automatic check_result(input logic [OUT_W-1:0] word);
        result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", word, '0);
            return;
        end
        want = expected_results.pop_front();
        if (word[0] !== want.entry_found)
            report_mismatch("entry_found", 32'(word[0]), 32'(want.entry_found));
        if (word[6:1] !== want.file_id)
            report_mismatch("file_id", 32'(word[6:1]), 32'(want.file_id));
        if (word[7] !== want.ids_exhausted)
            report_mismatch("ids_exhausted", 32'(word[7]), 32'(want.ids_exhausted));
        if (word[8] !== want.data_found)
            report_mismatch("data_found", 32'(word[8]), 32'(want.data_found));
        if (word[15:9] !== want.data_start_index)
            report_mismatch("data_start_index", 32'(word[15:9]), 32'(want.data_start_index));
        if (word[24:16] !== want.file_size)
            report_mismatch("file_size", 32'(word[24:16]), 32'(want.file_size));
        results_checked++;
    endtask

    // ---- journal generation ----

    function automatic block_t random_block();
        block_t w;
        for (int i = 0; i < WORDS; i++) w[i] = $urandom();
        return w;
    endfunction

    function automatic block_t sealed(input block_t w, input logic [31:0] seed, input bit good);
        w[WORDS-1] = journal_crc(seed, w, WORDS - 1);
        if (!good) w[WORDS-1] = w[WORDS-1] ^ (32'd1 << $urandom_range(0, 31));
        return w;
    endfunction

    function automatic block_t entry_block(input logic [ID_W-1:0] id, input logic [31:0] a,
                                           input logic [31:0] b, input logic [31:0] c,
                                           input bit good);
        block_t w;
        w = random_block();
        w[0][ID_W+1:0] = {id, KIND_ENTRY};
        w[1] = a;
        w[2] = b;
        w[3] = c;
        return sealed(w, '0, good);
    endfunction

    function automatic int pick_size();
        int edge_sizes [7];
        edge_sizes = '{0, 24, 25, 56, 57, 89, MAX_FILE_BYTES};
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, MAX_FILE_BYTES);
            1, 2: return edge_sizes[$urandom_range(0, 6)];
            default: return $urandom_range(0, 90);
        endcase
    endfunction

    task automatic push_item(input logic present, input logic eol, input block_t w);
        journal_item_t it;
        it.present = present;
        it.eol     = eol;
        it.words   = w;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_match(input logic [ID_W-1:0] id, input bit good);
        push_item(1'b1, 1'b0, entry_block(id, ident_target[0], ident_target[1],
                                          ident_target[2], good));
    endtask

    // valid entry whose identifier differs from the configured one
    task automatic push_other_entry(input logic [ID_W-1:0] id);
        logic [WORD_W-1:0] words [3];
        int k;
        words = ident_target;
        k = $urandom_range(0, 2);
        if ($urandom_range(0, 3) != 0) words[k] = words[k] ^ (32'd1 << $urandom_range(0, 31));
        else words[k] = words[k] ^ ($urandom() | 32'd1);
        push_item(1'b1, 1'b0, entry_block(id, words[0], words[1], words[2], 1'b1));
    endtask

    task automatic push_oversized(input logic [ID_W-1:0] id, input int size);
        block_t w;
        w = random_block();
        w[0][SIZE_W+7:0] = {SIZE_W'(size), id, KIND_START};
        push_item(1'b1, 1'b0, w);
    endtask

    task automatic push_chain(input logic [ID_W-1:0] id, input int size,
                              input chain_fault_e fault, input logic eol_last);
        block_t w;
        logic [31:0] seed;
        int rem;
        w = random_block();
        w[0][SIZE_W+7:0] = {SIZE_W'(size), id, KIND_START};
        if (size <= FIRST_LAST_BYTES) begin
            push_item(1'b1, eol_last, sealed(w, '0, fault != CHAIN_BAD_CRC));
            return;
        end
        push_item(1'b1, 1'b0, w);
        seed = journal_crc('0, w, WORDS);
        rem = size - FIRST_PAYLOAD;
        forever begin
            w = random_block();
            if (fault == CHAIN_BROKEN && ($urandom_range(0, 2) == 0 || rem <= CONT_LAST_BYTES)) begin
                w[0][0] = ~KIND_CONT;
                push_item(1'b1, eol_last, w);
                return;
            end
            w[0][0] = KIND_CONT;
            if (rem <= CONT_LAST_BYTES) begin
                push_item(1'b1, eol_last, sealed(w, seed, fault != CHAIN_BAD_CRC));
                return;
            end
            push_item(1'b1, 1'b0, w);
            seed = journal_crc(seed, w, WORDS);
            rem -= CONT_PAYLOAD;
        end
    endtask

    task automatic gen_journal(input int serial);
        int order [NUM_IDS];
        int first_item;
        int n;
        int k;
        int tmp;
        logic [ID_W-1:0] file_no;
        file_no = ID_W'($urandom());
        first_item = items_queued;

        // every id taken by other entries, sometimes with one left free
        if (serial % 16 == 6) begin
            for (int i = 0; i < NUM_IDS; i++) order[i] = i;
            for (int i = NUM_IDS - 1; i > 0; i--) begin
                k = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[k];
                order[k] = tmp;
            end
            n = ($urandom_range(0, 2) == 0) ? 1 : 0;
            for (int i = n; i < NUM_IDS; i++) push_other_entry(ID_W'(order[i]));
            if ($urandom_range(0, 2) == 0) begin
                push_match(file_no, 1'b1);
                push_chain(file_no, $urandom_range(0, FIRST_LAST_BYTES), CHAIN_GOOD, 1'b1);
            end else begin
                push_item(1'b0, 1'b1, random_block());
            end
            return;
        end

        // runs past the end of the log area; late chains must be ignored
        if (serial == 11) begin
            push_match(file_no, 1'b1);
            while (items_queued - first_item < LOG_BLOCKS + 6) begin
                push_chain(file_no, $urandom_range(0, FIRST_LAST_BYTES),
                           ($urandom_range(0, 3) == 0) ? CHAIN_BAD_CRC : CHAIN_GOOD, 1'b0);
            end
            push_item(1'b0, 1'b1, random_block());
            return;
        end

        n = $urandom_range(0, 5);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: push_item(1'b1, 1'b0, entry_block(ID_W'($urandom()), $urandom(), $urandom(),
                                                     $urandom(), 1'b0));
                1: push_item(1'b1, 1'b0, random_block());
                2: push_item(1'b0, 1'b0, random_block());
                default: push_other_entry(ID_W'($urandom()));
            endcase
        end
        if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 3) == 0) push_match(ID_W'($urandom()), 1'b0);
            push_match(file_no, 1'b1);
            n = $urandom_range(0, 4);
            repeat (n) begin
                case ($urandom_range(0, 11))
                    0: push_chain(file_no ^ ID_W'($urandom_range(1, NUM_IDS - 1)),
                                  $urandom_range(0, FIRST_LAST_BYTES), CHAIN_GOOD, 1'b0);
                    1: push_oversized(file_no, $urandom_range(MAX_FILE_BYTES + 1, SIZE_FIELD_MAX));
                    2: push_item(1'b1, 1'b0, random_block());
                    3: push_other_entry(ID_W'($urandom()));
                    4: push_item(1'b0, 1'b0, random_block());
                    5: push_chain(file_no, pick_size(), CHAIN_BAD_CRC, 1'b0);
                    6: push_chain(file_no, pick_size(), CHAIN_BROKEN, 1'b0);
                    default: push_chain(file_no, pick_size(), CHAIN_GOOD, 1'b0);
                endcase
            end
        end
        case ($urandom_range(0, 2))
            0: push_item(1'b0, 1'b1, random_block());
            1: push_item(1'b1, 1'b1, random_block());
            default: push_chain(file_no, $urandom_range(0, 60), CHAIN_GOOD, 1'b1);
        endcase
    endtask

    // ---- configuration ----

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ident_regs[idx] = value;
        regs_written++;
    endtask

    task automatic set_ident(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        ident_target[0] = a;
        ident_target[1] = b;
        ident_target[2] = c;
        write_reg(CFG_IDENT_A, a);
        write_reg(CFG_IDENT_B, b);
        write_reg(CFG_IDENT_C, c);
    endtask

    task automatic wait_idle();
        while (items_sent != items_queued || expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---- input word driver ----
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_item(on_bus);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    on_bus = pending_items.pop_front();
                    s_tdata  <= on_bus.words;
                    s_tlast  <= on_bus.eol;
                    s_tuser  <= on_bus.present;
                    s_tvalid <= 1'b1;
                    send_gap = steady ? 0 : $urandom_range(0, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---- result word monitor ----
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_hold = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                ready_hold = steady ? 0 : $urandom_range(0, 9);
            end else if (ready_hold > 0) begin
                ready_hold--;
            end
            m_tready <= (ready_hold == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     expected_results.size());
            $display("flash_journal_record_scanner_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        ident_regs = '{default: '0};
        ident_target = '{default: '0};
        restart_scan();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty log, a packed journal of corner cases, a short miss
        set_ident($urandom(), $urandom(), $urandom());
        push_item(1'b0, 1'b0, random_block());
        push_item(1'b0, 1'b1, random_block());

        push_other_entry(ID_W'(0));
        push_match(ID_W'(1), 1'b0);
        push_item(1'b1, 1'b0, '1);
        push_item(1'b1, 1'b0, '0);
        push_match(ID_W'(NUM_IDS - 1), 1'b1);
        push_chain(ID_W'(NUM_IDS - 1), FIRST_LAST_BYTES, CHAIN_GOOD, 1'b0);
        push_chain(ID_W'(NUM_IDS - 1), 0, CHAIN_BAD_CRC, 1'b0);
        push_oversized(ID_W'(NUM_IDS - 1), SIZE_FIELD_MAX);
        push_chain(ID_W'(NUM_IDS - 2), 10, CHAIN_GOOD, 1'b0);
        push_chain(ID_W'(NUM_IDS - 1), 60, CHAIN_GOOD, 1'b0);
        push_chain(ID_W'(NUM_IDS - 1), 60, CHAIN_BROKEN, 1'b0);
        push_other_entry(ID_W'(5));
        push_item(1'b0, 1'b0, random_block());
        push_item(1'b0, 1'b1, random_block());

        push_other_entry(ID_W'(0));
        push_other_entry(ID_W'(2));
        begin
            block_t w;
            w = random_block();
            w[0][1:0] = KIND_START;
            push_item(1'b1, 1'b1, w);
        end
        wait_idle();

        while (items_queued < ITEM_TARGET || predicted_results < RESULT_TARGET) begin
            case (phase_no % 4)
                0: set_ident('1, '1, '1);
                1: set_ident('0, '0, '0);
                2: set_ident($urandom(), $urandom(), $urandom());
                default: set_ident($urandom(), '1, '0);
            endcase
            steady = (phase_no % 3 == 2);
            repeat ($urandom_range(3, 6)) begin
                gen_journal(journals);
                journals++;
            end
            wait_idle();
            phase_no++;
        end

        $display("%0d journals, %0d blocks and markers, %0d register writes, %0d phases",
                 journals, items_sent, regs_written, phase_no);
        $display("%0d results checked: %0d matched, %0d with data, %0d with ids exhausted",
                 results_checked, matches_predicted, chains_predicted, exhausted_predicted);
        if (mismatches == 0) begin
            $display("flash_journal_record_scanner_core_tb: done, clean");
        end else begin
            $display("flash_journal_record_scanner_core_tb: done, errors");
        end
        $finish;
    end

endmodule
